// File: hdl/tkms_pkg.sv
// Shared types and constants for the top-k index selector.
`timescale 1ns / 1ps
`default_nettype none

package tkms_pkg;

    // Field and register widths
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 10;
    localparam int LEN_W   = 11;
    localparam int KCNT_W  = 7;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 32;

    // Parameter defaults
    localparam int MAX_SLICE_DEF = 1024;
    localparam int MAX_K_DEF     = 64;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_SLICE_LENGTH = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_K_COUNT      = 8'd1;

    // Register reset values
    localparam logic [LEN_W-1:0]  SLICE_LENGTH_RST = 11'd1024;
    localparam logic [KCNT_W-1:0] K_COUNT_RST      = 7'd20;

    // Contents of one cell as seen by its neighbors
    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
        logic             below;   // new word sorts ahead of this cell
    } t_cell_link;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             insert;
        logic             shift;
        logic             clear;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: hdl/topk_index_merge_sort.sv
// Top level: slice loader, insertion cell chain and index emitter.
// Each input word is inserted into a chain of MAX_K cells, one word per cycle while not stalled.
// The word that completes a slice of n words is followed, in the cycle after, by
// min(k, n) index words, one per cycle while not stalled.
// Input stalls during emission; the combinational insert compare in every cell sets the rate.
// Reset clears the cell valid bits and fill count; slice_length=1024, k_count=20.
`timescale 1ns / 1ps
`default_nettype none

module topk_index_merge_sort
    import tkms_pkg::*;
#(
    parameter int MAX_SLICE = MAX_SLICE_DEF,
    parameter int MAX_K     = MAX_K_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input channel
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic signed [VAL_W-1:0] i_sample_value,
    // output channel
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [IDX_W-1:0]         o_element_index,
    output logic                     o_last_index,
    // configuration
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CIDX_W-1:0]   i_cfg_index,
    input  wire logic [CDATA_W-1:0]  i_cfg_data
);

    localparam int FILL_W  = $clog2(MAX_SLICE);
    localparam int FILL1_W = $clog2(MAX_SLICE + 1);
    localparam int LW      = (FILL1_W > LEN_W) ? FILL1_W : LEN_W;
    localparam int KW      = $clog2(MAX_K + 1);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic              r_state, n_state;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [KW-1:0]     r_left, n_left;
    logic [LEN_W-1:0]  r_slice_length;
    logic [KCNT_W-1:0] r_k_count;

    logic [LW-1:0]     w_len_raw, w_len_eff, w_fill_ext, w_n, w_k_ext, w_emit;
    logic [KCNT_W-1:0] w_k_eff;
    logic              w_in_acc, w_out_acc;
    t_cell_ctrl        w_ctrl;
    t_cell_link        w_link [MAX_K];

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_length <= SLICE_LENGTH_RST;
            r_k_count      <= K_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SLICE_LENGTH: r_slice_length <= i_cfg_data[LEN_W-1:0];
                CFG_K_COUNT:      r_k_count      <= i_cfg_data[KCNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective length and count
    assign w_len_raw = LW'(r_slice_length);
    assign w_len_eff = (w_len_raw < LW'(2))         ? LW'(2) :
                       (w_len_raw > LW'(MAX_SLICE)) ? LW'(MAX_SLICE) : w_len_raw;
    assign w_k_eff   = (r_k_count == '0)            ? KCNT_W'(1) :
                       (r_k_count > KCNT_W'(MAX_K)) ? KCNT_W'(MAX_K) : r_k_count;
    assign w_k_ext   = LW'(w_k_eff);

    assign w_fill_ext = LW'(r_fill);
    assign w_n        = w_fill_ext + LW'(1);
    assign w_emit     = (w_k_ext > w_n) ? w_n : w_k_ext;

    // Handshakes
    assign o_stall   = (r_state != ST_LOAD);
    assign w_in_acc  = i_valid && (r_state == ST_LOAD);
    assign o_valid   = (r_state == ST_EMIT);
    assign w_out_acc = o_valid && !i_stall;

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_left  = r_left;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_n >= w_len_eff) begin
                        n_fill  = '0;
                        n_left  = w_emit[KW-1:0];
                        n_state = ST_EMIT;
                    end else begin
                        n_fill = w_n[FILL_W-1:0];
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_acc) begin
                    n_left = r_left - KW'(1);
                    if (r_left == KW'(1)) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_fill  <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_left  <= n_left;
        end
    end

    // Cell control: insert on load, shift toward head on emit, flush after the last word
    assign w_ctrl = '{
        insert: w_in_acc,
        shift:  w_out_acc,
        clear:  w_out_acc && (r_left == KW'(1)),
        value:  i_sample_value,
        index:  w_fill_ext[IDX_W-1:0]
    };

    // Cell chain
    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        t_cell_link w_prev, w_next;
        if (g == 0) begin : g_head
            assign w_prev = '{valid: 1'b0, value: '0, index: '0, below: 1'b0};
        end else begin : g_mid
            assign w_prev = w_link[g-1];
        end
        if (g == MAX_K - 1) begin : g_tail
            assign w_next = '{valid: 1'b0, value: '0, index: '0, below: 1'b0};
        end else begin : g_body
            assign w_next = w_link[g+1];
        end
        tkms_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_link  (w_link[g])
        );
    end

    // Head cell drives the result word
    assign o_element_index = w_link[0].index;
    assign o_last_index    = (r_left == KW'(1));

endmodule

`default_nettype wire

// File: hdl/tkms_cell.sv
// One sorting cell: holds a value and its index, inserts or shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module tkms_cell
    import tkms_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_cell_link i_prev,
    input  wire t_cell_link i_next,
    output t_cell_link      o_link
);

    logic             r_valid, n_valid;
    logic [VAL_W-1:0] r_value, n_value;
    logic [IDX_W-1:0] r_index, n_index;
    logic             w_below;

    // Strictly smaller goes ahead, so equal values keep arrival order
    assign w_below = !r_valid || ($signed(i_ctrl.value) < $signed(r_value));

    // Next contents
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_index = r_index;
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctrl.insert && w_below) begin
            if (i_prev.below) begin
                // upstream cell also moves down: take its word
                n_valid = i_prev.valid;
                n_value = i_prev.value;
                n_index = i_prev.index;
            end else begin
                n_valid = 1'b1;
                n_value = i_ctrl.value;
                n_index = i_ctrl.index;
            end
        end else if (i_ctrl.shift) begin
            n_valid = i_next.valid;
            n_value = i_next.value;
            n_index = i_next.index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_index <= n_index;
    end

    assign o_link = '{valid: r_valid, value: r_value, index: r_index, below: w_below};

endmodule

`default_nettype wire
